>>> hdl/bal_pkg.sv
`timescale 1ns / 1ps
// bal_pkg: widths, operation codes, status codes and the per-cell command type
// shared by the list cells and the top level of the bounded list engine
// no dependencies
package bal_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 4;
    localparam int LEN_W    = 5;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd2;
    localparam logic [OP_W-1:0] OP_SORTED = 3'd3;
    localparam logic [OP_W-1:0] OP_SHOW   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
    localparam logic [ST_W-1:0] ST_MISS   = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd4;

    typedef struct packed {
        logic ins;
        logic del;
        logic srt;
    } bal_cmd_t;

endpackage

>>> hdl/bal_cell.sv
`timescale 1ns / 1ps
// bal_cell: one list slot; holds an entry, compares it with the request value
// and takes its neighbour's entry on insert or delete shifts
// depends on bal_pkg
module bal_cell (
    input  logic                              clk,
    input  bal_pkg::bal_cmd_t                 cmd,
    input  logic [bal_pkg::IDX_W-1:0]         cell_index,
    input  logic [bal_pkg::LEN_W-1:0]         len,
    input  logic [bal_pkg::LEN_W-1:0]         position,
    input  logic signed [bal_pkg::DATA_W-1:0] value,
    input  logic signed [bal_pkg::DATA_W-1:0] lower_data,
    input  logic signed [bal_pkg::DATA_W-1:0] upper_data,
    input  logic                              suf_lower,
    input  logic                              suf_upper,
    input  logic                              found_lower,
    output logic                              suf_out,
    output logic                              found_out,
    output logic                              hit,
    output logic signed [bal_pkg::DATA_W-1:0] data
);
    import bal_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [LEN_W-1:0]         idx_ext;
    logic                     live;
    logic                     eq;
    logic                     gt;

    assign idx_ext   = {1'b0, cell_index};
    assign live      = idx_ext < len;
    assign eq        = live && (data_reg == value);
    assign gt        = data_reg > value;
    assign hit       = eq && !found_lower;
    assign found_out = found_lower || eq;
    // all entries from this slot to the end are greater than the value
    assign suf_out   = !live || (gt && suf_upper);
    assign data      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (idx_ext == position)
                data_next = value;
            else if (idx_ext > position && idx_ext <= len)
                data_next = lower_data;
        end
        else if (cmd.del)
        begin
            if (idx_ext >= position && (idx_ext + LEN_W'(1)) < len)
                data_next = upper_data;
        end
        else if (cmd.srt)
        begin
            if (idx_ext <= len)
            begin
                if (suf_lower)
                    data_next = lower_data;
                else if (suf_out)
                    data_next = value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

>>> hdl/bounded_array_list_engine.sv
`timescale 1ns / 1ps
// bounded_array_list_engine: top level; a row of list cells plus the length
// register, request decode, show sequencer and the result register
// depends on bal_pkg and bal_cell
//
// channel   valid      stall      transfer payload
// request   req_valid  req_stall  operation, value, position
// result    rsp_valid  rsp_stall  status, index, entry, length, last
//
// in insert, delete, locate and sorted insert every cell shifts or compares at once
// and the result lands in the output register
// show starts the sequencer, then reads entries one by one from the cells by a
// counter, held by result stalls; requests stall until its last transfer is loaded
// reset clears the length, the show sequencer and the result valid
// a request is taken only when the result register is empty or is read out
module bounded_array_list_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [bal_pkg::OP_W-1:0]          operation,
    input  logic signed [bal_pkg::DATA_W-1:0] value,
    input  logic [bal_pkg::LEN_W-1:0]         position,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [bal_pkg::ST_W-1:0]          status,
    output logic [bal_pkg::IDX_W-1:0]         index,
    output logic signed [bal_pkg::DATA_W-1:0] entry,
    output logic [bal_pkg::LEN_W-1:0]         length,
    output logic                              last
);
    import bal_pkg::*;

    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    logic                     show_active_reg;
    logic                     show_active_next;
    logic [IDX_W-1:0]         show_cnt_reg;
    logic [IDX_W-1:0]         show_cnt_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;

    logic [ST_W-1:0]          status_reg;
    logic [IDX_W-1:0]         index_reg;
    logic signed [DATA_W-1:0] entry_reg;
    logic [LEN_W-1:0]         length_reg;
    logic                     last_reg;

    logic                     out_free;
    logic                     accept;
    logic                     full;
    logic                     show_start;
    logic                     load;
    bal_cmd_t                 op_cmd;
    bal_cmd_t                 cmd;
    logic [ST_W-1:0]          res_status;
    logic [IDX_W-1:0]         res_index;
    logic [LEN_W-1:0]         res_len;
    logic signed [DATA_W-1:0] res_entry;
    logic                     res_last;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]      suf;
    logic [CAPACITY-1:0]      found;
    logic [CAPACITY-1:0]      hit;
    logic [IDX_W-1:0]         hit_index;
    logic                     any_hit;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = show_active_reg || !out_free;
    assign accept    = req_valid && !req_stall;
    assign full      = len_reg >= LEN_W'(CAPACITY);
    assign cmd       = accept ? op_cmd : '0;

    genvar j;
    generate
        for (j = 0; j < CAPACITY; j++)
        begin : g_cell
            bal_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .cell_index  (IDX_W'(j)),
                .len         (len_reg),
                .position    (position),
                .value       (value),
                .lower_data  ((j == 0) ? '0 : cell_data[(j == 0) ? 0 : j - 1]),
                .upper_data  ((j == CAPACITY - 1) ? '0
                              : cell_data[(j == CAPACITY - 1) ? j : j + 1]),
                .suf_lower   ((j == 0) ? 1'b0 : suf[(j == 0) ? 0 : j - 1]),
                .suf_upper   ((j == CAPACITY - 1) ? 1'b1
                              : suf[(j == CAPACITY - 1) ? j : j + 1]),
                .found_lower ((j == 0) ? 1'b0 : found[(j == 0) ? 0 : j - 1]),
                .suf_out     (suf[j]),
                .found_out   (found[j]),
                .hit         (hit[j]),
                .data        (cell_data[j])
            );
        end
    endgenerate

    // first match is one-hot, so the encode is a plain or
    always_comb
    begin
        hit_index = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (hit[k])
                hit_index = hit_index | IDX_W'(k);
        end
    end
    assign any_hit = |hit;

    always_comb
    begin
        op_cmd     = '0;
        res_status = ST_OK;
        res_index  = '0;
        res_len    = len_reg;
        show_start = 1'b0;
        case (operation)
            OP_INSERT:
            begin
                if (full)
                    res_status = ST_FULL;
                else if (position > len_reg)
                    res_status = ST_BADPOS;
                else
                begin
                    op_cmd.ins = 1'b1;
                    res_len    = len_reg + LEN_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (position >= len_reg)
                    res_status = ST_BADPOS;
                else
                begin
                    op_cmd.del = 1'b1;
                    res_len    = len_reg - LEN_W'(1);
                end
            end
            OP_LOCATE:
            begin
                if (len_reg == '0)
                    res_status = ST_EMPTY;
                else if (!any_hit)
                    res_status = ST_MISS;
                else
                    res_index = hit_index;
            end
            OP_SORTED:
            begin
                if (full)
                    res_status = ST_FULL;
                else
                begin
                    op_cmd.srt = 1'b1;
                    res_len    = len_reg + LEN_W'(1);
                end
            end
            OP_SHOW:
            begin
                if (len_reg == '0)
                    res_status = ST_EMPTY;
                else
                    show_start = 1'b1;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        len_next         = len_reg;
        show_active_next = show_active_reg;
        show_cnt_next    = show_cnt_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        load             = 1'b0;
        res_entry        = '0;
        res_last         = 1'b1;
        if (accept)
        begin
            len_next = res_len;
            if (show_start)
            begin
                show_active_next = 1'b1;
                show_cnt_next    = '0;
            end
            else
            begin
                load           = 1'b1;
                rsp_valid_next = 1'b1;
            end
        end
        else if (show_active_reg && out_free)
        begin
            load           = 1'b1;
            rsp_valid_next = 1'b1;
            res_entry      = cell_data[show_cnt_reg];
            res_last       = ({1'b0, show_cnt_reg} + LEN_W'(1)) == len_reg;
            show_cnt_next  = show_cnt_reg + IDX_W'(1);
            if (res_last)
                show_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg         <= '0;
            show_active_reg <= 1'b0;
            show_cnt_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            len_reg         <= len_next;
            show_active_reg <= show_active_next;
            show_cnt_reg    <= show_cnt_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (show_active_reg)
            begin
                status_reg <= ST_OK;
                index_reg  <= show_cnt_reg;
            end
            else
            begin
                status_reg <= res_status;
                index_reg  <= res_index;
            end
            entry_reg  <= res_entry;
            length_reg <= len_next;
            last_reg   <= res_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign index     = index_reg;
    assign entry     = entry_reg;
    assign length    = length_reg;
    assign last      = last_reg;

endmodule

>>> bench/bounded_array_list_engine_tb.sv
`timescale 1ns / 1ps
// bounded_array_list_engine_tb: directed table then random list operations, each result
// checked against the typed row or a shadow copy of the list kept by the bench
// depends on bal_pkg and bounded_array_list_engine
module bounded_array_list_engine_tb;

    import bal_pkg::*;

    localparam logic [OP_W-1:0]          OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0]          OP_SPARE_HI  = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MIN      = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX      = 32'sh7FFF_FFFF;
    localparam int                       RANDOM_ITEMS = 150;
    localparam int                       QUIET_ITEMS  = 30;
    localparam int                       CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [ST_W-1:0]          st;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] ent;
        logic [LEN_W-1:0]         len;
        logic                     fin;
    } list_result_t;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        logic [LEN_W-1:0]         pos;
        int                       reps;
        bit                       typed;
        logic [ST_W-1:0]          st;
        logic [IDX_W-1:0]         idx;
        logic [LEN_W-1:0]         len;
    } list_row_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     req_valid  = 1'b0;
    logic                     req_stall;
    logic [OP_W-1:0]          operation  = OP_SHOW;
    logic signed [DATA_W-1:0] value      = '0;
    logic [LEN_W-1:0]         position   = '0;
    logic                     rsp_valid;
    logic                     rsp_stall  = 1'b0;
    logic [ST_W-1:0]          status;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] entry;
    logic [LEN_W-1:0]         length;
    logic                     last;

    logic signed [DATA_W-1:0] shadow_store [CAPACITY];
    int                       shadow_len     = 0;
    list_result_t             due_results [$];
    int                       mismatch_count = 0;
    int                       items_sent     = 0;
    int                       stall_left     = 0;
    int                       cycles         = 0;
    bit                       quiet          = 1'b0;

    // typed rows carry status, index and length; the rest come from the shadow list
    list_row_t directed_rows [20] = '{
        '{OP_SHOW,   32'sd0,  5'd0,  1,  1'b1, ST_EMPTY,  4'd0, 5'd0},
        '{OP_LOCATE, 32'sd0,  5'd0,  1,  1'b1, ST_EMPTY,  4'd0, 5'd0},
        '{OP_DELETE, 32'sd0,  5'd0,  1,  1'b1, ST_BADPOS, 4'd0, 5'd0},
        '{OP_INSERT, 32'sd1,  5'd1,  1,  1'b1, ST_BADPOS, 4'd0, 5'd0},
        '{OP_INSERT, VAL_MAX, 5'd0,  1,  1'b1, ST_OK,     4'd0, 5'd1},
        '{OP_INSERT, VAL_MIN, 5'd0,  1,  1'b1, ST_OK,     4'd0, 5'd2},
        '{OP_INSERT, 32'sd0,  5'd2,  1,  1'b1, ST_OK,     4'd0, 5'd3},
        '{OP_LOCATE, VAL_MIN, 5'd0,  1,  1'b1, ST_OK,     4'd0, 5'd3},
        '{OP_LOCATE, 32'sd5,  5'd0,  1,  1'b1, ST_MISS,   4'd0, 5'd3},
        '{OP_SORTED, -32'sd1, 5'd0,  1,  1'b0, ST_OK,     4'd0, 5'd0},
        '{OP_SHOW,   32'sd0,  5'd0,  1,  1'b0, ST_OK,     4'd0, 5'd0},
        '{OP_DELETE, 32'sd0,  5'd31, 1,  1'b1, ST_BADPOS, 4'd0, 5'd4},
        '{OP_SPARE_LO, 32'sd9, 5'd3, 1,  1'b1, ST_OK,     4'd0, 5'd4},
        '{OP_SORTED, 32'sd7,  5'd0,  12, 1'b0, ST_OK,     4'd0, 5'd0},
        '{OP_INSERT, 32'sd3,  5'd31, 1,  1'b1, ST_FULL,   4'd0, 5'd16},
        '{OP_SORTED, -32'sd5, 5'd31, 1,  1'b1, ST_FULL,   4'd0, 5'd16},
        '{OP_SHOW,   32'sd0,  5'd0,  1,  1'b0, ST_OK,     4'd0, 5'd0},
        '{OP_DELETE, 32'sd0,  5'd15, 1,  1'b1, ST_OK,     4'd0, 5'd15},
        '{OP_LOCATE, 32'sd7,  5'd0,  1,  1'b0, ST_OK,     4'd0, 5'd0},
        '{OP_DELETE, 32'sd0,  5'd0,  1,  1'b1, ST_OK,     4'd0, 5'd14}
    };

    bounded_array_list_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .value     (value),
        .position  (position),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .index     (index),
        .entry     (entry),
        .length    (length),
        .last      (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic apply_list_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                                 input logic [LEN_W-1:0] pos, input bit record);
        logic [ST_W-1:0]  st;
        logic [IDX_W-1:0] idx;
        int               i;
        st  = ST_OK;
        idx = '0;
        case (op)
            OP_INSERT:
            begin
                if (shadow_len >= CAPACITY)
                    st = ST_FULL;
                else if (pos > shadow_len)
                    st = ST_BADPOS;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_store[i] = shadow_store[i-1];
                    shadow_store[pos] = val;
                    shadow_len++;
                end
            end
            OP_DELETE:
            begin
                if (pos >= shadow_len)
                    st = ST_BADPOS;
                else
                begin
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_store[i] = shadow_store[i+1];
                    shadow_len--;
                end
            end
            OP_LOCATE:
            begin
                if (shadow_len == 0)
                    st = ST_EMPTY;
                else
                begin
                    i = 0;
                    while (i < shadow_len && shadow_store[i] != val)
                        i++;
                    if (i < shadow_len)
                        idx = i[IDX_W-1:0];
                    else
                        st = ST_MISS;
                end
            end
            OP_SORTED:
            begin
                if (shadow_len >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    i = shadow_len;
                    while (i > 0 && shadow_store[i-1] > val)
                    begin
                        shadow_store[i] = shadow_store[i-1];
                        i--;
                    end
                    shadow_store[i] = val;
                    shadow_len++;
                end
            end
            OP_SHOW:
            begin
                if (shadow_len == 0)
                    st = ST_EMPTY;
                else
                begin
                    if (record)
                        for (i = 0; i < shadow_len; i++)
                            due_results.push_back('{ST_OK, i[IDX_W-1:0], shadow_store[i],
                                                    shadow_len[LEN_W-1:0], i + 1 == shadow_len});
                    return;
                end
            end
            default:
            begin
            end
        endcase
        if (record)
            due_results.push_back('{st, idx, '0, shadow_len[LEN_W-1:0], 1'b1});
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 4)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        if (roll >= 5 && roll <= 6)
            return $signed($urandom_range(0, 40)) - 32'sd20;
        if (roll >= 7 && shadow_len > 0)
            return shadow_store[$urandom_range(0, shadow_len - 1)];
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_operation(input bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 35 : 15))
            return OP_INSERT;
        if (roll < (filling ? 60 : 27))
            return OP_SORTED;
        if (roll < (filling ? 72 : 67))
            return OP_DELETE;
        if (roll < (filling ? 87 : 85))
            return OP_LOCATE;
        if (roll < 96)
            return OP_SHOW;
        return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    task automatic sender_idle();
        if (!quiet && (items_sent / 25) % 3 != 2 && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                             input logic [LEN_W-1:0] pos, input bit typed,
                             input list_result_t typed_res);
        operation <= op;
        value     <= val;
        position  <= pos;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        apply_list_op(op, val, pos, !typed);
        if (typed)
            due_results.push_back(typed_res);
        items_sent++;
    endtask

    task automatic check_field(input string name, input logic signed [32:0] want,
                               input logic signed [32:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (quiet)
            stall_left = 0;
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 9);
        rsp_stall <= (stall_left != 0);
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none actual status %0d entry %0d",
                         $time, status, entry);
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("status", want.st, status);
                check_field("index", want.idx, index);
                check_field("entry", want.ent, entry);
                check_field("length", want.len, length);
                check_field("last", want.fin, last);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        logic [LEN_W-1:0]         pos;
        list_result_t             typed_res;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            typed_res = '{directed_rows[r].st, directed_rows[r].idx, '0, directed_rows[r].len, 1'b1};
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                sender_idle();
                send_item(directed_rows[r].op, directed_rows[r].val, directed_rows[r].pos,
                          directed_rows[r].typed, typed_res);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // hold off until the list has drained every result
            if (n == RANDOM_ITEMS / 2)
            begin
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while (due_results.size() != 0);
            end
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            sender_idle();
            op = pick_operation((n / 30) % 2 == 0);
            if ($urandom_range(0, 4) == 0)
                pos = LEN_W'($urandom_range(0, 31));
            else if (op == OP_DELETE && shadow_len > 0)
                pos = LEN_W'($urandom_range(0, shadow_len - 1));
            else
                pos = LEN_W'($urandom_range(0, shadow_len));
            val = pick_value();
            send_item(op, val, pos, 1'b0, '0);
        end

        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
